// File: sv/range_prime_counter_defines.svh
// Assertion macros for the range prime counter.
`ifndef RANGE_PRIME_COUNTER_DEFINES_SVH
`define RANGE_PRIME_COUNTER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define RPC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("range_prime_counter: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define RPC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("range_prime_counter: next-cycle check failed");

`endif

// File: sv/rpc_pkg.sv
// Shared constants, types and microcode table of the range prime counter.
package rpc_pkg;

  localparam int unsigned ValueWidth = 16;
  localparam int unsigned CandWidth  = ValueWidth + 1;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned BitCntWidth = $clog2(ValueWidth + 1);
  localparam int unsigned StepWidth  = 4;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [ValueWidth-1:0] ValTwo   = ValueWidth'(2);
  localparam logic [ValueWidth-1:0] ValThree = ValueWidth'(3);
  localparam logic [CandWidth-1:0]  CandThree = CandWidth'(3);
  localparam logic [CandWidth-1:0]  CandNine  = CandWidth'(9);

  localparam logic [StepWidth-1:0] StepWait      = 4'd0;
  localparam logic [StepWidth-1:0] StepInit      = 4'd1;
  localparam logic [StepWidth-1:0] StepTestN     = 4'd2;
  localparam logic [StepWidth-1:0] StepTestD     = 4'd3;
  localparam logic [StepWidth-1:0] StepDiv       = 4'd4;
  localparam logic [StepWidth-1:0] StepCheck     = 4'd5;
  localparam logic [StepWidth-1:0] StepNextD     = 4'd6;
  localparam logic [StepWidth-1:0] StepPrime     = 4'd7;
  localparam logic [StepWidth-1:0] StepComposite = 4'd8;
  localparam logic [StepWidth-1:0] StepDone      = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_D_INIT,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_D_ADV,
    OP_N_ADV,
    OP_COUNT_ADV,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_IN_VALID,
    COND_N_ABOVE_HI,
    COND_SQ_ABOVE_N,
    COND_DIV_LAST,
    COND_REM_ZERO,
    COND_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e                  op;
    cond_e                cond;
    logic [StepWidth-1:0] target;
    logic                 hold;
  } ctrl_word_t;

  typedef struct packed {
    op_e  op;
    logic in_take;
  } dp_ctrl_t;

  typedef struct packed {
    logic n_above_hi;
    logic sq_above_n;
    logic div_last;
    logic rem_zero;
  } dp_status_t;

  function automatic ctrl_word_t micro_rom(input logic [StepWidth-1:0] step);
    ctrl_word_t cw;
    unique case (step)
      StepWait:      cw = '{op: OP_LOAD,      cond: COND_IN_VALID,   target: StepInit,
                            hold: 1'b1};
      StepInit:      cw = '{op: OP_INIT,      cond: COND_NEVER,      target: StepWait,
                            hold: 1'b0};
      StepTestN:     cw = '{op: OP_D_INIT,    cond: COND_N_ABOVE_HI, target: StepDone,
                            hold: 1'b0};
      StepTestD:     cw = '{op: OP_DIV_START, cond: COND_SQ_ABOVE_N, target: StepPrime,
                            hold: 1'b0};
      StepDiv:       cw = '{op: OP_DIV_STEP,  cond: COND_DIV_LAST,   target: StepCheck,
                            hold: 1'b1};
      StepCheck:     cw = '{op: OP_NOP,       cond: COND_REM_ZERO,   target: StepComposite,
                            hold: 1'b0};
      StepNextD:     cw = '{op: OP_D_ADV,     cond: COND_ALWAYS,     target: StepTestD,
                            hold: 1'b0};
      StepPrime:     cw = '{op: OP_COUNT_ADV, cond: COND_ALWAYS,     target: StepTestN,
                            hold: 1'b0};
      StepComposite: cw = '{op: OP_N_ADV,     cond: COND_ALWAYS,     target: StepTestN,
                            hold: 1'b0};
      StepDone:      cw = '{op: OP_EMIT,      cond: COND_OUT_FREE,   target: StepWait,
                            hold: 1'b1};
      default:       cw = '{op: OP_NOP,       cond: COND_ALWAYS,     target: StepWait,
                            hold: 1'b0};
    endcase
    return cw;
  endfunction

endpackage

// File: sv/rpc_datapath.sv
// Datapath of the range prime counter: bounds, candidate, divisor, remainder, count.
module rpc_datapath (
  input  logic                            clk_i,
  input  logic [15:0]                     range_low_i,
  input  logic [15:0]                     range_high_i,
  input  rpc_pkg::dp_ctrl_t               ctrl_i,
  output rpc_pkg::dp_status_t             status_o,
  output logic [rpc_pkg::CountWidth-1:0]  count_o
);

  logic [rpc_pkg::ValueWidth-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [rpc_pkg::CandWidth-1:0]   n_q, n_d, d_q, d_d, sq_q, sq_d, rem_q, rem_d;
  logic [rpc_pkg::CandWidth-1:0]   rem_sh;
  logic [rpc_pkg::BitCntWidth-1:0] bitcnt_q, bitcnt_d, bit_idx;
  logic [rpc_pkg::CountWidth-1:0]  count_q, count_d;

  assign bit_idx = bitcnt_q - 1'b1;
  assign rem_sh  = {rem_q[rpc_pkg::CandWidth-2:0], n_q[bit_idx]};

  always_comb begin
    lo_d     = lo_q;
    hi_d     = hi_q;
    n_d      = n_q;
    d_d      = d_q;
    sq_d     = sq_q;
    rem_d    = rem_q;
    bitcnt_d = bitcnt_q;
    count_d  = count_q;
    unique case (ctrl_i.op)
      rpc_pkg::OP_LOAD: begin
        if (ctrl_i.in_take) begin
          lo_d = range_low_i[rpc_pkg::ValueWidth-1:0];
          hi_d = range_high_i[rpc_pkg::ValueWidth-1:0];
        end
      end
      rpc_pkg::OP_INIT: begin
        count_d = (lo_q <= rpc_pkg::ValTwo && hi_q >= rpc_pkg::ValTwo) ?
                  rpc_pkg::CountWidth'(1) : '0;
        n_d     = (lo_q < rpc_pkg::ValThree) ? rpc_pkg::CandThree :
                  {1'b0, lo_q | rpc_pkg::ValueWidth'(1)};
      end
      rpc_pkg::OP_D_INIT: begin
        d_d  = rpc_pkg::CandThree;
        sq_d = rpc_pkg::CandNine;
      end
      rpc_pkg::OP_DIV_START: begin
        rem_d    = '0;
        bitcnt_d = rpc_pkg::BitCntWidth'(rpc_pkg::ValueWidth);
      end
      rpc_pkg::OP_DIV_STEP: begin
        rem_d    = (rem_sh >= d_q) ? rem_sh - d_q : rem_sh;
        bitcnt_d = bitcnt_q - 1'b1;
      end
      rpc_pkg::OP_D_ADV: begin
        d_d  = d_q + rpc_pkg::CandWidth'(2);
        sq_d = sq_q + rpc_pkg::CandWidth'({d_q, 2'b00}) + rpc_pkg::CandWidth'(4);
      end
      rpc_pkg::OP_N_ADV: begin
        n_d = n_q + rpc_pkg::CandWidth'(2);
      end
      rpc_pkg::OP_COUNT_ADV: begin
        n_d = n_q + rpc_pkg::CandWidth'(2);
        if (count_q != rpc_pkg::CountMax) begin
          count_d = count_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    n_q      <= n_d;
    d_q      <= d_d;
    sq_q     <= sq_d;
    rem_q    <= rem_d;
    bitcnt_q <= bitcnt_d;
    count_q  <= count_d;
  end

  assign status_o.n_above_hi = n_q > {1'b0, hi_q};
  assign status_o.sq_above_n = sq_q > n_q;
  assign status_o.div_last   = bitcnt_q == rpc_pkg::BitCntWidth'(1);
  assign status_o.rem_zero   = rem_q == '0;
  assign count_o             = count_q;

endmodule

// File: sv/range_prime_counter.sv
// Step sequence per range: the input transfer, Init, then per odd candidate TestN and per trial
// divisor TestD, Div, Check and NextD, ending in Prime or Composite; past the high bound, Done.
// Each trial divisor runs a restoring remainder in the Div step, one quotient bit a cycle.
// Throughput: one range at a time; input ready rises the cycle after the count enters the
// output register, which holds it until transferred.
// Reset clears the step counter and the output valid; datapath registers hold no reset.
`include "range_prime_counter_defines.svh"

module range_prime_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] range_low_i,
  input  logic [15:0] range_high_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] prime_count_o
);

  logic [rpc_pkg::StepWidth-1:0]  step_q, step_d;
  rpc_pkg::ctrl_word_t            cw;
  rpc_pkg::dp_ctrl_t              dp_ctrl;
  rpc_pkg::dp_status_t            dp_status;
  logic [rpc_pkg::CountWidth-1:0] count;
  logic                           cond_true;
  logic                           out_free;
  logic                           emit;
  logic                           out_valid_q, out_valid_d;
  logic [15:0]                    out_count_q, out_count_d;

  assign cw       = rpc_pkg::micro_rom(step_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = (cw.op == rpc_pkg::OP_EMIT) && out_free;

  assign in_ready_o      = cw.op == rpc_pkg::OP_LOAD;
  assign dp_ctrl.op      = cw.op;
  assign dp_ctrl.in_take = in_valid_i && in_ready_o;

  rpc_datapath u_datapath (
    .clk_i        (clk_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .ctrl_i       (dp_ctrl),
    .status_o     (dp_status),
    .count_o      (count)
  );

  always_comb begin
    unique case (cw.cond)
      rpc_pkg::COND_NEVER:      cond_true = 1'b0;
      rpc_pkg::COND_ALWAYS:     cond_true = 1'b1;
      rpc_pkg::COND_IN_VALID:   cond_true = in_valid_i;
      rpc_pkg::COND_N_ABOVE_HI: cond_true = dp_status.n_above_hi;
      rpc_pkg::COND_SQ_ABOVE_N: cond_true = dp_status.sq_above_n;
      rpc_pkg::COND_DIV_LAST:   cond_true = dp_status.div_last;
      rpc_pkg::COND_REM_ZERO:   cond_true = dp_status.rem_zero;
      rpc_pkg::COND_OUT_FREE:   cond_true = out_free;
      default:                  cond_true = 1'b0;
    endcase
    priority if (cond_true) begin
      step_d = cw.target;
    end else if (cw.hold) begin
      step_d = step_q;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_count_d = out_count_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_count_d = count[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= rpc_pkg::StepWait;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign prime_count_o = out_count_q;

  `RPC_ASSERT_NEXT(a_emit_loads_out, emit, out_valid_o && prime_count_o == $past(count))
  `RPC_ASSERT_NEXT(a_take_starts_init, dp_ctrl.in_take, step_q == rpc_pkg::StepInit && !in_ready_o)
  `RPC_ASSERT_NEXT(a_div_stays_or_checks, step_q == rpc_pkg::StepDiv,
                   step_q == rpc_pkg::StepDiv || step_q == rpc_pkg::StepCheck)

endmodule

// File: test/tb_range_prime_counter.sv
// Testbench for range_prime_counter: directed and random ranges with a burst driver, checked by a prime counter.
`timescale 1ns / 1ps

module tb_range_prime_counter;

  localparam int unsigned CycleLimit = 20_000_000;
  localparam int unsigned DrainCycles = 3000;
  localparam int unsigned LongHoldCycles = 5000;
  localparam int unsigned LongHoldAfter = 40;
  localparam int unsigned RandomRanges = 80;

  typedef struct {
    logic [15:0] lo;
    logic [15:0] hi;
    bit          drain;
  } range_req_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] range_low = '0;
  logic [15:0] range_high = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] prime_count;

  range_req_t  pending_q[$];
  logic [15:0] prime_count_q[$];

  int unsigned accepted_cnt = 0;
  int unsigned counted_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  int unsigned window_left = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  bit          held_once = 1'b0;

  range_prime_counter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .range_low_i   (range_low),
    .range_high_i  (range_high),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .prime_count_o (prime_count)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [15:0] count_primes(input logic [15:0] lo, input logic [15:0] hi);
    int unsigned n;
    int unsigned d;
    int unsigned total;
    bit          is_prime;
    total = 0;
    if (lo <= hi) begin
      for (n = lo; n <= hi; n++) begin
        is_prime = (n >= 2);
        if (n > 2 && n % 2 == 0) is_prime = 1'b0;
        for (d = 3; is_prime && d * d <= n; d += 2) begin
          if (n % d == 0) is_prime = 1'b0;
        end
        if (is_prime && total < 16'hFFFF) total++;
      end
    end
    return total[15:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic add_range(input int unsigned lo, input int unsigned hi, input bit drain);
    range_req_t req;
    req.lo = lo[15:0];
    req.hi = hi[15:0];
    req.drain = drain;
    pending_q.push_back(req);
  endtask

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      range_low  <= '0;
      range_high <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 &&
                   (!pending_q[0].drain || (!in_valid && accepted_cnt == counted_cnt))) begin
        in_valid   <= 1'b1;
        range_low  <= pending_q[0].lo;
        range_high <= pending_q[0].hi;
        void'(pending_q.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern per window, plus one long hold-off
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      window_left <= 0;
      stall_mode  <= 0;
      hold_left   <= 0;
      held_once   <= 1'b0;
    end else if (!held_once && counted_cnt == LongHoldAfter) begin
      held_once <= 1'b1;
      hold_left <= LongHoldCycles;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (window_left == 0) begin
        stall_mode  <= $urandom_range(0, 3);
        window_left <= $urandom_range(8, 80);
      end else begin
        window_left <= window_left - 1;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i or negedge rst_n) begin : monitor
    logic [15:0] want;
    if (!rst_n) begin
      accepted_cnt <= 0;
      counted_cnt  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        prime_count_q.push_back(count_primes(range_low, range_high));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid && out_ready) begin
        counted_cnt <= counted_cnt + 1;
        if (prime_count_q.size() == 0) begin
          report_mismatch($sformatf("unexpected prime_count %0d", prime_count));
        end else begin
          want = prime_count_q.pop_front();
          if (prime_count !== want) begin
            report_mismatch($sformatf("result %0d: prime_count %0d, want %0d",
                                      counted_cnt, prime_count, want));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycle_cnt);
      $display("tb_range_prime_counter: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int unsigned lo;
    int unsigned hi;
    add_range(0, 0, 1'b0);
    add_range(0, 1, 1'b0);
    add_range(1, 1, 1'b0);
    add_range(0, 2, 1'b0);
    add_range(2, 2, 1'b0);
    add_range(2, 3, 1'b0);
    add_range(3, 3, 1'b0);
    add_range(4, 4, 1'b0);
    add_range(9, 9, 1'b0);
    add_range(25, 25, 1'b0);
    add_range(3, 1, 1'b0);
    add_range(65535, 0, 1'b0);
    add_range(65535, 65534, 1'b0);
    add_range(65535, 65535, 1'b0);
    add_range(65521, 65521, 1'b0);
    add_range(65519, 65535, 1'b0);
    add_range(0, 100, 1'b1);
    add_range(1000, 1100, 1'b0);
    add_range(32768, 32790, 1'b0);
    add_range(0, 1000, 1'b0);
    add_range(21845, 21860, 1'b0);
    for (int i = 0; i < RandomRanges; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        lo = $urandom_range(1, 65535);
        hi = $urandom_range(0, lo - 1);
      end else if (kind < 20) begin
        lo = $urandom_range(0, 300);
        hi = lo + $urandom_range(0, 200);
      end else if (kind < 25) begin
        lo = $urandom_range(0, 65535);
        hi = lo + $urandom_range(0, 100);
      end else begin
        lo = $urandom_range(0, 65535);
        hi = lo + $urandom_range(0, 15);
      end
      if (hi > 65535) hi = 65535;
      add_range(lo, hi, (i == 60));
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    while (pending_q.size() != 0 || in_valid || prime_count_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_range_prime_counter: clean");
    end else begin
      $display("tb_range_prime_counter: errors");
    end
    $finish;
  end

endmodule

// File: range_prime_counter.f
+incdir+sv
sv/rpc_pkg.sv
sv/rpc_datapath.sv
sv/range_prime_counter.sv
test/tb_range_prime_counter.sv
